FILE: hdl/cts_pkg.sv
// Shared types, widths and reciprocal constants for the Taylor cosine pipeline.
`default_nettype none
package cts_pkg;

	localparam int TERM_STEPS  = 15;
	localparam int RECIP_COUNT = 15;
	localparam int STEP_W      = $clog2(RECIP_COUNT + 1);

	localparam int ANGLE_W = 32;
	localparam int COS_W   = 32;
	localparam int FRAC_W  = 40;
	localparam int OUT_FRAC_W = 30;
	localparam int SQ_W    = 2 * ANGLE_W;
	localparam int X2_W    = SQ_W - 18;
	localparam int X2_SHIFT = SQ_W - X2_W;
	localparam int MAG_W   = 49;
	localparam int PROD_W  = 56;
	localparam int RECIP_W = 40;
	localparam int ACC_W   = 53;

	localparam int CELL_STAGES = 5;
	localparam int LATENCY     = 2 + CELL_STAGES * TERM_STEPS + 1;

	localparam logic [MAG_W-1:0] MAG_ONE = MAG_W'(1) << FRAC_W;
	localparam logic signed [ACC_W-1:0] ACC_ONE = ACC_W'(1) << FRAC_W;
	localparam logic signed [COS_W-1:0] COS_ONE = COS_W'(1) << OUT_FRAC_W;

	// round(2^40 / ((2n-1)(2n))) for step n
	localparam logic [RECIP_W-1:0] RECIP_TABLE [1:RECIP_COUNT] = '{
		40'd549755813888,
		40'd91625968981,
		40'd36650387593,
		40'd19634136210,
		40'd12216795864,
		40'd8329633544,
		40'd6041272680,
		40'd4581298449,
		40'd3593175254,
		40'd2893451652,
		40'd2379895298,
		40'd1991868891,
		40'd1691556350,
		40'd1454380460,
		40'd1263806469
	};

	typedef struct packed {
		logic                    valid;
		logic [X2_W-1:0]         x2;
		logic [MAG_W-1:0]        mag;
		logic signed [ACC_W-1:0] acc;
	} term_t;

endpackage
`default_nettype wire

FILE: hdl/cts_square.sv
// Front stages: square the angle, round to Q.40 and seed the term chain.
`default_nettype none
module cts_square (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  logic [cts_pkg::ANGLE_W-1:0]  angle,
	output cts_pkg::term_t               dst
);
	import cts_pkg::*;

	logic              valid_s1;
	logic [SQ_W-1:0]   sq_s1;
	logic              valid_s2;
	logic [X2_W-1:0]   x2_s2;
	logic [SQ_W-1:0]   sq_rnd;

	assign sq_rnd = sq_s1 + (SQ_W'(1) << (X2_SHIFT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		sq_s1 <= SQ_W'(angle) * SQ_W'(angle);
		x2_s2 <= sq_rnd[X2_SHIFT +: X2_W];
	end

	assign dst.valid = valid_s2;
	assign dst.x2    = x2_s2;
	assign dst.mag   = MAG_ONE;
	assign dst.acc   = ACC_ONE;

endmodule
`default_nettype wire

FILE: hdl/cts_cell.sv
// One series term: next magnitude from x^2 and a reciprocal, then accumulate.
`default_nettype none
module cts_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [cts_pkg::STEP_W-1:0]  step,
	input  cts_pkg::term_t              src,
	output cts_pkg::term_t              dst
);
	import cts_pkg::*;

	localparam int M_LO = 24;
	localparam int M_HI = MAG_W - M_LO;
	localparam int X_LO = 23;
	localparam int X_HI = X2_W - X_LO;
	localparam int P_LO = 28;
	localparam int P_HI = PROD_W - P_LO;
	localparam int R_LO = 20;
	localparam int R_HI = RECIP_W - R_LO;
	localparam int SUM_W = 96;

	logic [RECIP_W-1:0] recip;

	logic                    valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [X2_W-1:0]         x2_s1, x2_s2, x2_s3, x2_s4, x2_s5;
	logic signed [ACC_W-1:0] acc_s1, acc_s2, acc_s3, acc_s4, acc_s5;

	logic [M_LO+X_LO-1:0] pa0_s1;
	logic [M_LO+X_HI-1:0] pa1_s1;
	logic [M_HI+X_LO-1:0] pa2_s1;
	logic [M_HI+X_HI-1:0] pa3_s1;
	logic [PROD_W-1:0]    p_s2;
	logic [P_LO+R_LO-1:0] q0_s3;
	logic [P_LO+R_HI-1:0] q1_s3;
	logic [P_HI+R_LO-1:0] q2_s3;
	logic [P_HI+R_HI-1:0] q3_s3;
	logic [MAG_W-1:0]     mag_s4;
	logic [MAG_W-1:0]     mag_s5;

	logic [SUM_W-1:0]        sum1, sum2;
	logic signed [ACC_W-1:0] term;

	assign recip = RECIP_TABLE[step];

	assign sum1 = SUM_W'(pa0_s1)
		+ (SUM_W'(pa1_s1) << X_LO)
		+ (SUM_W'(pa2_s1) << M_LO)
		+ (SUM_W'(pa3_s1) << (M_LO + X_LO))
		+ (SUM_W'(1) << (FRAC_W - 1));

	assign sum2 = SUM_W'(q0_s3)
		+ (SUM_W'(q1_s3) << R_LO)
		+ (SUM_W'(q2_s3) << P_LO)
		+ (SUM_W'(q3_s3) << (P_LO + R_LO))
		+ (SUM_W'(1) << (FRAC_W - 1));

	assign term = $signed({{(ACC_W - MAG_W){1'b0}}, mag_s4});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= src.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		pa0_s1 <= (M_LO+X_LO)'(src.mag[M_LO-1:0]) * (M_LO+X_LO)'(src.x2[X_LO-1:0]);
		pa1_s1 <= (M_LO+X_HI)'(src.mag[M_LO-1:0]) * (M_LO+X_HI)'(src.x2[X2_W-1:X_LO]);
		pa2_s1 <= (M_HI+X_LO)'(src.mag[MAG_W-1:M_LO]) * (M_HI+X_LO)'(src.x2[X_LO-1:0]);
		pa3_s1 <= (M_HI+X_HI)'(src.mag[MAG_W-1:M_LO]) * (M_HI+X_HI)'(src.x2[X2_W-1:X_LO]);
		x2_s1  <= src.x2;
		acc_s1 <= src.acc;

		p_s2   <= sum1[FRAC_W +: PROD_W];
		x2_s2  <= x2_s1;
		acc_s2 <= acc_s1;

		q0_s3  <= (P_LO+R_LO)'(p_s2[P_LO-1:0]) * (P_LO+R_LO)'(recip[R_LO-1:0]);
		q1_s3  <= (P_LO+R_HI)'(p_s2[P_LO-1:0]) * (P_LO+R_HI)'(recip[RECIP_W-1:R_LO]);
		q2_s3  <= (P_HI+R_LO)'(p_s2[PROD_W-1:P_LO]) * (P_HI+R_LO)'(recip[R_LO-1:0]);
		q3_s3  <= (P_HI+R_HI)'(p_s2[PROD_W-1:P_LO]) * (P_HI+R_HI)'(recip[RECIP_W-1:R_LO]);
		x2_s3  <= x2_s2;
		acc_s3 <= acc_s2;

		mag_s4 <= sum2[FRAC_W +: MAG_W];
		x2_s4  <= x2_s3;
		acc_s4 <= acc_s3;

		// odd steps subtract, even steps add
		acc_s5 <= step[0] ? (acc_s4 - term) : (acc_s4 + term);
		mag_s5 <= mag_s4;
		x2_s5  <= x2_s4;
	end

	assign dst.valid = valid_s5;
	assign dst.x2    = x2_s5;
	assign dst.mag   = mag_s5;
	assign dst.acc   = acc_s5;

endmodule
`default_nettype wire

FILE: hdl/cosine_taylor_series.sv
// Top level: 16-term Taylor cosine, Q3.29 angle in, Q2.30 cosine out.
// One angle is taken every clock cycle; busy never rises. Each result appears
// on cosine with done high for exactly one cycle, after the start that carried
// its angle has passed the square-and-round registers, the 15 term cells (two
// split multiplies, each followed by a partial-product sum, then the accumulate)
// and the output register that holds the saturated, rounded sum. Results leave
// in input order and the receiver cannot stall.
`default_nettype none
module cosine_taylor_series (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [cts_pkg::ANGLE_W-1:0]        angle,
	output logic                               done,
	output logic signed [cts_pkg::COS_W-1:0]   cosine
);
	import cts_pkg::*;

	term_t chain [0:TERM_STEPS];

	logic                    done_q;
	logic signed [COS_W-1:0] cosine_q;
	logic signed [COS_W-1:0] cos_d;
	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] acc_rnd;

	assign busy = 1'b0;

	cts_square u_square (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (start),
		.angle  (angle),
		.dst    (chain[0])
	);

	for (genvar i = 0; i < TERM_STEPS; i++) begin : g_cell
		cts_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (STEP_W'(i + 1)),
			.src    (chain[i]),
			.dst    (chain[i+1])
		);
	end

	assign acc     = chain[TERM_STEPS].acc;
	assign acc_rnd = acc + (ACC_W'(1) << (FRAC_W - OUT_FRAC_W - 1));

	always_comb begin
		if (acc > ACC_ONE) begin
			cos_d = COS_ONE;
		end else if (acc < -ACC_ONE) begin
			cos_d = -COS_ONE;
		end else begin
			cos_d = acc_rnd[(FRAC_W - OUT_FRAC_W) +: COS_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= chain[TERM_STEPS].valid;
		end
	end

	always_ff @(posedge clk) begin
		cosine_q <= cos_d;
	end

	assign done   = done_q;
	assign cosine = cosine_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("result missing after fixed latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result without matching transaction");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (cosine <= COS_ONE && cosine >= -COS_ONE))
		else $error("cosine outside saturation bounds");

endmodule
`default_nettype wire
